[rtl/rsti_pkg.sv]
// Shared types, constants and the character decoder of the radix string parser.
package rsti_pkg;

  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 6;
  localparam int VALUE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic               SIGNED_RESET = 1'b1;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] NO_DIGIT   = 8'hFF;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               neg;
  } res_t;

  function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = NO_DIGIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h57;
    end
    return d;
  endfunction

endpackage

[rtl/rsti_ifs.sv]
// Channel interfaces: character input, parsed value output and register writes.
interface rsti_char_if;
  import rsti_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              last_char;
  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

interface rsti_res_if;
  import rsti_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface rsti_cfg_if;
  import rsti_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/rsti_cfg_regs.sv]
// Configuration registers: radix and signed mode.
module rsti_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  rsti_cfg_if.sink      cfg,
  output rsti_pkg::cfg_t regs
);
  import rsti_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.radix       <= RADIX_RESET;
      regs.signed_mode <= SIGNED_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_RADIX:  regs.radix       <= cfg.data[RADIX_W-1:0];
        CFG_SIGNED: regs.signed_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/rsti_core.sv]
// Input register, per-character parse step with its state, and pending result register.
module rsti_core (
  input  logic           clk,
  input  logic           rst,
  input  rsti_pkg::cfg_t regs,
  rsti_char_if.sink      chars,
  output logic           res_valid,
  input  logic           res_ready,
  output rsti_pkg::res_t res
);
  import rsti_pkg::*;

  logic              in_v;
  logic [CHAR_W-1:0] in_c;
  logic              in_last;

  logic [VALUE_W-1:0] acc;
  logic               minus_seen;
  logic               at_start;
  logic               halted;

  logic [VALUE_W-1:0] acc_next;
  logic               minus_next;
  logic               at_start_next;
  logic               halted_next;

  logic [CHAR_W-1:0]          digit;
  logic [VALUE_W+RADIX_W-1:0] prod;
  logic                       res_free;
  logic                       proc;

  assign res_free    = !res_valid || res_ready;
  assign proc        = in_v && (!in_last || res_free);
  assign chars.ready = !in_v || proc;

  assign digit = digit_of(in_c);
  assign prod  = acc * regs.radix;

  always_comb begin
    acc_next      = acc;
    minus_next    = minus_seen;
    at_start_next = at_start;
    halted_next   = halted;
    if (!halted) begin
      at_start_next = 1'b0;
      if (at_start && regs.signed_mode && (in_c == MINUS_CHAR || in_c == PLUS_CHAR)) begin
        minus_next = (in_c == MINUS_CHAR);
      end else if (digit < {{(CHAR_W-RADIX_W){1'b0}}, regs.radix}) begin
        acc_next = prod[VALUE_W-1:0] + {{(VALUE_W-CHAR_W){1'b0}}, digit};
      end else begin
        halted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v       <= 1'b0;
      res_valid  <= 1'b0;
      acc        <= '0;
      minus_seen <= 1'b0;
      at_start   <= 1'b1;
      halted     <= 1'b0;
    end else begin
      if (chars.ready) begin
        in_v <= chars.valid;
      end
      if (proc) begin
        if (in_last) begin
          acc        <= '0;
          minus_seen <= 1'b0;
          at_start   <= 1'b1;
          halted     <= 1'b0;
        end else begin
          acc        <= acc_next;
          minus_seen <= minus_next;
          at_start   <= at_start_next;
          halted     <= halted_next;
        end
      end
      if (proc && in_last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_c    <= chars.char_byte;
      in_last <= chars.last_char;
    end
    if (proc && in_last) begin
      res.acc <= acc_next;
      res.neg <= regs.signed_mode && minus_next;
    end
  end

endmodule

[rtl/rsti_out_stage.sv]
// Output register: applies the sign and holds the value beat until taken.
module rsti_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  rsti_pkg::res_t res,
  rsti_res_if.source     result
);
  import rsti_pkg::*;

  logic               out_v;
  logic [VALUE_W-1:0] out_value;

  assign res_ready    = !out_v || result.ready;
  assign result.valid = out_v;
  assign result.value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (res_ready) begin
      out_v <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_value <= res.neg ? (VALUE_W'(0) - res.acc) : res.acc;
    end
  end

endmodule

[rtl/radix_string_to_integer_top.sv]
// Top level of the radix string parser.
// The value beat of a final character passes the input, pending result and output registers in turn.
// Throughput: one character per cycle unless stalled; 64x6 parse multiply-add sets the path.
// Two value beats can wait; characters stall only when a third final character meets both.
// Reset (rst, synchronous): radix 10, signed mode on, parser state cleared, no beat pending.
module radix_string_to_integer_top (
  input logic        clk,
  input logic        rst,
  rsti_char_if.sink  chars,
  rsti_res_if.source result,
  rsti_cfg_if.sink   cfg
);
  import rsti_pkg::*;

  cfg_t regs;
  logic res_valid;
  logic res_ready;
  res_t res;

  rsti_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rsti_core u_core (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .chars     (chars),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rsti_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .result    (result)
  );

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    !chars.ready |-> (result.valid && res_valid))
    else $error("character stall without a waiting value beat");

  a_regs_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cfg.valid && cfg.ready) |-> $stable(regs))
    else $error("configuration changed without a write");

  a_pending_drains: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> result.valid)
    else $error("value beat lost between stages");

endmodule
